// ===== rtl/scbd_pkg.sv =====
// Shared constants and types of the sliced channel byte decoder.
`default_nettype none
package scbd_pkg;

  localparam int MAX_SLICES   = 4;
  localparam int MAX_CHANNELS = 16;
  localparam int PLANE_BITS   = 20;

  localparam int SLICE_W = $clog2(MAX_SLICES);
  localparam int CHAN_W  = $clog2(MAX_CHANNELS);
  localparam int CNT_W   = CHAN_W + 1;
  localparam int PSIZE_W = PLANE_BITS + 1;
  localparam int BOUND_W = 5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PLANE_PIXELS  = 3'd0;
  localparam logic [2:0] REG_CHANNEL_TOTAL = 3'd1;
  localparam logic [2:0] REG_SLICE_COUNT   = 3'd2;
  localparam logic [2:0] REG_SLICE_BOUNDS  = 3'd3;
  localparam logic [2:0] REG_SLICE_CODES   = 3'd4;
  localparam logic [2:0] REG_UNUSED_PAD    = 3'd5;

  localparam logic [15:0] FIX_ONE      = 16'd32;
  localparam logic [15:0] FLOW_INVALID = 16'h7FFF;
  localparam logic [2:0]  LAST_BIT     = 3'd7;

  typedef enum logic [1:0] {
    ENC_BYTE = 2'd0,
    ENC_FLOW = 2'd1,
    ENC_BITS = 2'd2,
    ENC_BAD  = 2'd3
  } enc_t;

endpackage
`default_nettype wire

// ===== rtl/sliced_channel_byte_decoder_unit.sv =====
// Top level of the sliced channel byte decoder: config registers, slice walk, decode.
//
//  channel | direction | ports                        | notes
//  in_     | input     | data_byte, start_sample      | one raw payload byte per item
//  out_    | output    | element_value + flags        | 0..8 results per input item
//  cfg_    | APB       | psel/penable/pwrite/paddr    | six registers at 4*i
//
// Byte, flow and invalid slices decode an input byte in a single step; a bit-plane byte
// yields one element per step, up to 8, as the single result register holds one element.
// A flow low byte is held without a result and frees the input without waiting on out_ready.
// rst_n is synchronous; it clears the registers to their defaults and the counters.
// The output register lets a new byte start while a result waits on out_ready.
`default_nettype none
module sliced_channel_byte_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_element_value,
  output logic             out_element_invalid,
  output logic             out_format_error,
  output logic [1:0]       out_slice_number,
  output logic             out_last_of_sample,
  output logic             out_last_of_byte,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [scbd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [scbd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [scbd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration registers
  logic [scbd_pkg::PSIZE_W-1:0] plane_pixels_r;
  logic [4:0]                   channel_total_r;
  logic [2:0]                   slice_count_r;
  logic [15:0]                  slice_bounds_r;
  logic [7:0]                   slice_codes_r;
  logic                         unused_pad_r;

  // walk state
  logic [scbd_pkg::SLICE_W-1:0]    slice_r, slice_nxt;
  logic [scbd_pkg::CHAN_W-1:0]     chan_r, chan_nxt;
  logic [scbd_pkg::PLANE_BITS-1:0] pix_r, pix_nxt;
  logic [7:0]                      held_r, held_nxt;
  logic                            due_r, due_nxt;

  // input register
  logic       busy_r;
  logic [7:0] byte_r;
  logic       start_r;
  logic [2:0] bit_r;

  // output register
  logic              out_valid_r;
  logic [15:0]       val_r, val_nxt;
  logic              inv_r, inv_nxt;
  logic              err_r, err_nxt;
  logic [1:0]        osl_r;
  logic              los_r, los_nxt;
  logic              lob_r, lob_nxt;

  logic cfg_wr;
  logic in_acc;

  // derived layout
  logic [4:0]                   nch;
  logic [2:0]                   nsl;
  logic [scbd_pkg::PSIZE_W-1:0] psize;
  logic [scbd_pkg::CNT_W-1:0]   send   [scbd_pkg::MAX_SLICES];
  logic [scbd_pkg::CNT_W-1:0]   sstart [scbd_pkg::MAX_SLICES];
  logic [scbd_pkg::MAX_SLICES-1:0] nonempty;
  logic [scbd_pkg::SLICE_W-1:0] rs_idx;

  // step logic
  logic                         stale, restart_now;
  logic [scbd_pkg::SLICE_W-1:0] cur_s, nxt_idx;
  logic [scbd_pkg::CHAN_W-1:0]  cur_ch;
  logic [scbd_pkg::PLANE_BITS-1:0] cur_pix;
  logic                         cur_due, nxt_found;
  scbd_pkg::enc_t               code;
  logic                         hold, emit, plane_end, slice_done, sample_end, step_last;
  logic                         step_en;
  logic [scbd_pkg::PSIZE_W-1:0] pix_inc;
  logic [scbd_pkg::CNT_W-1:0]   ch_inc;
  logic [15:0]                  flow_v;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_pixels_r  <= scbd_pkg::PSIZE_W'(1);
      channel_total_r <= 5'd1;
      slice_count_r   <= 3'd1;
      slice_bounds_r  <= '0;
      slice_codes_r   <= '0;
      unused_pad_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        scbd_pkg::REG_PLANE_PIXELS:  plane_pixels_r  <= cfg_pwdata[scbd_pkg::PSIZE_W-1:0];
        scbd_pkg::REG_CHANNEL_TOTAL: channel_total_r <= cfg_pwdata[4:0];
        scbd_pkg::REG_SLICE_COUNT:   slice_count_r   <= cfg_pwdata[2:0];
        scbd_pkg::REG_SLICE_BOUNDS:  slice_bounds_r  <= cfg_pwdata[15:0];
        scbd_pkg::REG_SLICE_CODES:   slice_codes_r   <= cfg_pwdata[7:0];
        scbd_pkg::REG_UNUSED_PAD:    unused_pad_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      scbd_pkg::REG_PLANE_PIXELS:  cfg_prdata = 32'(plane_pixels_r);
      scbd_pkg::REG_CHANNEL_TOTAL: cfg_prdata = 32'(channel_total_r);
      scbd_pkg::REG_SLICE_COUNT:   cfg_prdata = 32'(slice_count_r);
      scbd_pkg::REG_SLICE_BOUNDS:  cfg_prdata = 32'(slice_bounds_r);
      scbd_pkg::REG_SLICE_CODES:   cfg_prdata = 32'(slice_codes_r);
      scbd_pkg::REG_UNUSED_PAD:    cfg_prdata = 32'(unused_pad_r);
      default:                     cfg_prdata = '0;
    endcase
  end

  // Clamped layout: slice ends, starts and which slices hold channels
  always_comb begin
    logic [4:0] b;
    b = '0;
    nch = (channel_total_r == 5'd0) ? 5'd1 :
          (channel_total_r > 5'(scbd_pkg::MAX_CHANNELS)) ? 5'(scbd_pkg::MAX_CHANNELS) :
          channel_total_r;
    nsl = (slice_count_r == 3'd0) ? 3'd1 :
          (slice_count_r > 3'(scbd_pkg::MAX_SLICES)) ? 3'(scbd_pkg::MAX_SLICES) :
          slice_count_r;
    psize = (plane_pixels_r == '0) ? scbd_pkg::PSIZE_W'(1) :
            (plane_pixels_r > (scbd_pkg::PSIZE_W'(1) << scbd_pkg::PLANE_BITS)) ?
            (scbd_pkg::PSIZE_W'(1) << scbd_pkg::PLANE_BITS) : plane_pixels_r;
    for (int s = 0; s < scbd_pkg::MAX_SLICES; s++) begin
      if ((3'(s + 1) >= nsl) || (s >= 3)) begin
        send[s] = nch;
      end else begin
        b = slice_bounds_r[scbd_pkg::BOUND_W*s +: scbd_pkg::BOUND_W];
        send[s] = (b > nch) ? nch : b;
      end
    end
    sstart[0] = '0;
    for (int s = 1; s < scbd_pkg::MAX_SLICES; s++) begin
      sstart[s] = send[s-1];
    end
    for (int s = 0; s < scbd_pkg::MAX_SLICES; s++) begin
      nonempty[s] = (3'(s) < nsl) && (sstart[s] < send[s]);
    end
    rs_idx = '0;
    for (int s = scbd_pkg::MAX_SLICES - 1; s >= 0; s--) begin
      if (nonempty[s]) rs_idx = scbd_pkg::SLICE_W'(s);
    end
  end

  // One decode step per cycle on the byte in the input register, unless an emitting step waits on out_ready
  always_comb begin
    stale = start_r || (3'(slice_r) >= nsl) ||
            ({1'b0, chan_r} < sstart[slice_r]) || ({1'b0, chan_r} >= send[slice_r]) ||
            ({1'b0, pix_r} >= psize);
    restart_now = (bit_r == 3'd0) && stale;
    cur_s   = restart_now ? rs_idx : slice_r;
    cur_ch  = restart_now ? sstart[rs_idx][scbd_pkg::CHAN_W-1:0] : chan_r;
    cur_pix = restart_now ? '0 : pix_r;
    cur_due = restart_now ? 1'b0 : due_r;
    code    = scbd_pkg::enc_t'(slice_codes_r[2*cur_s +: 2]);
    hold    = (code == scbd_pkg::ENC_FLOW) && !cur_due;
    emit    = !hold;

    pix_inc    = {1'b0, cur_pix} + scbd_pkg::PSIZE_W'(1);
    ch_inc     = {1'b0, cur_ch} + scbd_pkg::CNT_W'(1);
    plane_end  = pix_inc >= psize;
    slice_done = ch_inc >= send[cur_s];
    nxt_idx    = '0;
    nxt_found  = 1'b0;
    for (int s = scbd_pkg::MAX_SLICES - 1; s >= 0; s--) begin
      if (nonempty[s] && (scbd_pkg::SLICE_W'(s) > cur_s)) begin
        nxt_idx   = scbd_pkg::SLICE_W'(s);
        nxt_found = 1'b1;
      end
    end
    sample_end = plane_end && slice_done && !nxt_found;

    slice_nxt = cur_s;
    chan_nxt  = cur_ch;
    pix_nxt   = cur_pix;
    held_nxt  = hold ? byte_r : held_r;
    due_nxt   = hold;
    if (emit) begin
      if (!plane_end) begin
        pix_nxt = pix_inc[scbd_pkg::PLANE_BITS-1:0];
      end else begin
        pix_nxt = '0;
        if (!slice_done) begin
          chan_nxt = ch_inc[scbd_pkg::CHAN_W-1:0];
        end else if (nxt_found) begin
          slice_nxt = nxt_idx;
          chan_nxt  = sstart[nxt_idx][scbd_pkg::CHAN_W-1:0];
        end else begin
          slice_nxt = rs_idx;
          chan_nxt  = sstart[rs_idx][scbd_pkg::CHAN_W-1:0];
        end
      end
    end

    flow_v  = {byte_r, held_r};
    inv_nxt = 1'b0;
    err_nxt = 1'b0;
    case (code)
      scbd_pkg::ENC_BYTE: val_nxt = {3'b000, byte_r, 5'b00000};
      scbd_pkg::ENC_FLOW: begin
        inv_nxt = (flow_v == scbd_pkg::FLOW_INVALID);
        val_nxt = inv_nxt ? 16'd0 : flow_v;
      end
      scbd_pkg::ENC_BITS: val_nxt = byte_r[bit_r] ? scbd_pkg::FIX_ONE : 16'd0;
      default: begin
        val_nxt = 16'd0;
        err_nxt = 1'b1;
      end
    endcase
    step_last = (code != scbd_pkg::ENC_BITS) || (bit_r == scbd_pkg::LAST_BIT) || plane_end;
    los_nxt   = sample_end;
    lob_nxt   = step_last;
  end

  assign step_en  = busy_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !busy_r || (step_en && step_last);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
      slice_r     <= '0;
      chan_r      <= '0;
      pix_r       <= '0;
      held_r      <= '0;
      due_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
      end else if (step_en) begin
        busy_r <= !step_last;
        bit_r  <= step_last ? 3'd0 : bit_r + 3'd1;
      end
      if (step_en) begin
        slice_r <= slice_nxt;
        chan_r  <= chan_nxt;
        pix_r   <= pix_nxt;
        held_r  <= held_nxt;
        due_r   <= due_nxt;
      end
      if (step_en && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r  <= in_data_byte;
      start_r <= in_start_sample;
    end
    if (step_en && emit) begin
      val_r <= val_nxt;
      inv_r <= inv_nxt;
      err_r <= err_nxt;
      osl_r <= cur_s;
      los_r <= los_nxt;
      lob_r <= lob_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_element_value   = val_r;
  assign out_element_invalid = inv_r;
  assign out_format_error    = err_r;
  assign out_slice_number    = osl_r;
  assign out_last_of_sample  = los_r;
  assign out_last_of_byte    = lob_r;

  // Only bit-plane bytes span more than one step
  a_multi_step_bits: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (bit_r != 3'd0) |-> code == scbd_pkg::ENC_BITS)
    else $error("multi-step item outside bit-plane slice");

  a_idle_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> bit_r == 3'd0)
    else $error("bit index not cleared while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> (val_r == 16'd0) && !inv_r)
    else $error("format error element carries data");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && inv_r |-> val_r == 16'd0)
    else $error("invalid flow element carries data");

  a_sample_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && los_r |-> lob_r)
    else $error("sample end not last of its byte");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the sliced channel byte decoder unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD    = 6;
  localparam int SETTLE_CYCLES  = 16;   // covers an eight-element bit-plane byte
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEG_ITEMS      = 25;

  typedef struct packed {
    logic signed [15:0] value;
    logic               invalid;
    logic               fmt_err;
    logic [1:0]         slice;
    logic               last_sample;
    logic               last_byte;
  } elem_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic [7:0]  data;
    bit          start;
    bit          typed;
    elem_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_data_byte = '0;
  logic in_start_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_element_value;
  logic out_element_invalid, out_format_error, out_last_of_sample, out_last_of_byte;
  logic [1:0] out_slice_number;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [scbd_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [scbd_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [scbd_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  sliced_channel_byte_decoder_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_start_sample(in_start_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_element_value(out_element_value), .out_element_invalid(out_element_invalid),
    .out_format_error(out_format_error), .out_slice_number(out_slice_number),
    .out_last_of_sample(out_last_of_sample), .out_last_of_byte(out_last_of_byte),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Decoder model: register copies and walk position
  logic [20:0] m_plane;
  logic [4:0]  m_chan_total;
  logic [2:0]  m_slice_cnt;
  logic [15:0] m_bounds;
  logic [7:0]  m_codes;
  logic        m_pad;
  int unsigned cur_slice, cur_chan, cur_pixel;
  logic [7:0]  low_byte;
  bit          pair_half;

  elem_t fresh[0:7];
  int    n_fresh;
  elem_t pending_elems[$];
  stim_row_t dir_rows[$];

  int error_count = 0;
  int bytes_sent = 0;
  int elems_checked = 0;
  int reg_writes = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  elem_t head_elem;

  function automatic int unsigned eff_slices();
    int unsigned n = m_slice_cnt;
    if (n < 1) n = 1;
    if (n > scbd_pkg::MAX_SLICES) n = scbd_pkg::MAX_SLICES;
    return n;
  endfunction

  function automatic int unsigned eff_channels();
    int unsigned t = m_chan_total;
    if (t < 1) t = 1;
    if (t > scbd_pkg::MAX_CHANNELS) t = scbd_pkg::MAX_CHANNELS;
    return t;
  endfunction

  function automatic int unsigned eff_plane();
    int unsigned p = m_plane;
    if (p < 1) p = 1;
    if (p > (1 << scbd_pkg::PLANE_BITS)) p = 1 << scbd_pkg::PLANE_BITS;
    return p;
  endfunction

  // exclusive end channel of a slice; the last slice in use ends at the channel count
  function automatic int unsigned slice_last(int unsigned s);
    int unsigned t = eff_channels();
    int unsigned b;
    if (s + 1 >= eff_slices() || s >= 3) return t;
    b = (m_bounds >> (5 * s)) & 31;
    return (b > t) ? t : b;
  endfunction

  function automatic int unsigned slice_first(int unsigned s);
    return (s == 0) ? 0 : slice_last(s - 1);
  endfunction

  function automatic int unsigned first_filled(int unsigned s);
    int unsigned n = eff_slices();
    while (s < n && slice_first(s) >= slice_last(s)) s++;
    return s;
  endfunction

  function automatic void rewind_sample();
    int unsigned s = first_filled(0);
    cur_slice = s;
    cur_chan  = slice_first(s);
    cur_pixel = 0;
    pair_half = 1'b0;
  endfunction

  // bit 0: plane done, bit 1: sample done
  function automatic logic [1:0] step_element();
    logic [1:0] fl = 2'b00;
    int unsigned s;
    cur_pixel++;
    if (cur_pixel >= eff_plane()) begin
      fl[0] = 1'b1;
      cur_pixel = 0;
      cur_chan++;
      if (cur_chan >= slice_last(cur_slice)) begin
        s = first_filled(cur_slice + 1);
        if (s >= eff_slices()) begin
          fl[1] = 1'b1;
          rewind_sample();
        end else begin
          cur_slice = s;
          cur_chan  = slice_first(s);
        end
      end
    end
    return fl;
  endfunction

  function automatic void add_elem(logic [15:0] v, logic inv, logic err, int unsigned s,
                                   logic last);
    fresh[n_fresh].value       = v;
    fresh[n_fresh].invalid     = inv;
    fresh[n_fresh].fmt_err     = err;
    fresh[n_fresh].slice       = s[1:0];
    fresh[n_fresh].last_sample = last;
    fresh[n_fresh].last_byte   = 1'b0;
    n_fresh++;
  endfunction

  // Elements produced by one payload byte land in fresh[0 .. n_fresh-1]
  function automatic void decode_byte(logic [7:0] b, bit st);
    int unsigned s;
    scbd_pkg::enc_t code;
    logic [1:0] fl;
    logic [15:0] v;
    n_fresh = 0;
    if (st) rewind_sample();
    s = cur_slice;
    if (s >= eff_slices() || cur_chan < slice_first(s) || cur_chan >= slice_last(s) ||
        cur_pixel >= eff_plane())
      rewind_sample();
    s = cur_slice;
    code = scbd_pkg::enc_t'(m_codes[2*s +: 2]);
    if (code != scbd_pkg::ENC_FLOW) pair_half = 1'b0;
    case (code)
      scbd_pkg::ENC_BYTE: begin
        fl = step_element();
        add_elem({3'b000, b, 5'b00000}, 1'b0, 1'b0, s, fl[1]);
      end
      scbd_pkg::ENC_FLOW: begin
        if (!pair_half) begin
          low_byte  = b;
          pair_half = 1'b1;
        end else begin
          v = {b, low_byte};
          pair_half = 1'b0;
          fl = step_element();
          if (v == scbd_pkg::FLOW_INVALID) add_elem(16'd0, 1'b1, 1'b0, s, fl[1]);
          else add_elem(v, 1'b0, 1'b0, s, fl[1]);
        end
      end
      scbd_pkg::ENC_BITS: begin
        for (int i = 0; i < 8; i++) begin
          fl = step_element();
          add_elem(b[i] ? scbd_pkg::FIX_ONE : 16'd0, 1'b0, 1'b0, s, fl[1]);
          if (fl[0]) break;   // plane ends: padding bits of this byte are dropped
        end
      end
      default: begin
        fl = step_element();
        add_elem(16'd0, 1'b0, 1'b1, s, fl[1]);
      end
    endcase
    if (n_fresh > 0) fresh[n_fresh-1].last_byte = 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Stimulus table builders
  function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, data: '0, start: 1'b0, typed: 1'b0,
          want: '0};
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_item(logic [7:0] d, bit st);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, data: d, start: st, typed: 1'b0,
          want: '0};
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_typed(logic [7:0] d, bit st, logic [15:0] v, logic inv,
                                    logic err, logic last);
    stim_row_t r;
    r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, data: d, start: st, typed: 1'b1,
          want: '0};
    r.want.value       = v;
    r.want.invalid     = inv;
    r.want.fmt_err     = err;
    r.want.slice       = 2'd0;
    r.want.last_sample = last;
    r.want.last_byte   = 1'b1;
    dir_rows = {dir_rows, r};
  endfunction

  task automatic send_item(input logic [7:0] d, input bit st, input bit typed,
                           input elem_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_start_sample <= st;
    do @(posedge clk); while (!in_ready);
    decode_byte(d, st);
    if (typed) pending_elems = {pending_elems, want};
    else for (int i = 0; i < n_fresh; i++) pending_elems = {pending_elems, fresh[i]};
    bytes_sent++;
  endtask

  // Drop valid, let every expected element drain, then allow for a byte still in work
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      scbd_pkg::REG_PLANE_PIXELS:  m_plane      = val[20:0];
      scbd_pkg::REG_CHANNEL_TOTAL: m_chan_total = val[4:0];
      scbd_pkg::REG_SLICE_COUNT:   m_slice_cnt  = val[2:0];
      scbd_pkg::REG_SLICE_BOUNDS:  m_bounds     = val[15:0];
      scbd_pkg::REG_SLICE_CODES:   m_codes      = val[7:0];
      scbd_pkg::REG_UNUSED_PAD:    m_pad        = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_layout(input logic [31:0] plane, input logic [31:0] chans,
                             input logic [31:0] cnt, input logic [31:0] bounds,
                             input logic [31:0] codes, input logic [31:0] pad);
    write_reg(scbd_pkg::REG_PLANE_PIXELS, plane);
    write_reg(scbd_pkg::REG_CHANNEL_TOTAL, chans);
    write_reg(scbd_pkg::REG_SLICE_COUNT, cnt);
    write_reg(scbd_pkg::REG_SLICE_BOUNDS, bounds);
    write_reg(scbd_pkg::REG_SLICE_CODES, codes);
    write_reg(scbd_pkg::REG_UNUSED_PAD, pad);
  endtask

  // Output side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_elems.size() == 0) begin
        flag_error($sformatf("element %0d arrived with nothing expected", out_element_value));
      end else begin
        head_elem = pending_elems.pop_front();
        if (out_element_value !== head_elem.value)
          flag_error($sformatf("value %0d, expected %0d", out_element_value, head_elem.value));
        if (out_element_invalid !== head_elem.invalid)
          flag_error($sformatf("invalid flag %b, expected %b", out_element_invalid,
                               head_elem.invalid));
        if (out_format_error !== head_elem.fmt_err)
          flag_error($sformatf("format error %b, expected %b", out_format_error,
                               head_elem.fmt_err));
        if (out_slice_number !== head_elem.slice)
          flag_error($sformatf("slice %0d, expected %0d", out_slice_number, head_elem.slice));
        if (out_last_of_sample !== head_elem.last_sample)
          flag_error($sformatf("last of sample %b, expected %b", out_last_of_sample,
                               head_elem.last_sample));
        if (out_last_of_byte !== head_elem.last_byte)
          flag_error($sformatf("last of byte %b, expected %b", out_last_of_byte,
                               head_elem.last_byte));
        elems_checked++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] d;
    bit st;
    m_plane = 21'd1; m_chan_total = 5'd1; m_slice_cnt = 3'd1;
    m_bounds = '0; m_codes = '0; m_pad = 1'b0;
    cur_slice = 0; cur_chan = 0; cur_pixel = 0; low_byte = '0; pair_half = 1'b0;

    // Directed: reset layout, every encoding, saturation, empty slices, stale position
    add_typed(8'hFF, 1'b1, 16'h1FE0, 1'b0, 1'b0, 1'b1);
    add_typed(8'h00, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
    add_cfg(scbd_pkg::REG_SLICE_CODES, 32'hFF);
    add_typed(8'h5A, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1);
    add_cfg(scbd_pkg::REG_SLICE_CODES, 32'h01);
    add_item(8'hFF, 1'b0);
    add_typed(8'h7F, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b1);
    add_item(8'h00, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h12, 1'b0);             // low half only, then the mode changes
    add_cfg(scbd_pkg::REG_SLICE_CODES, 32'h00);
    add_item(8'h34, 1'b0);
    add_cfg(scbd_pkg::REG_PLANE_PIXELS, 32'd3);  // bit-plane planes shorter than a byte
    add_cfg(scbd_pkg::REG_CHANNEL_TOTAL, 32'd2);
    add_cfg(scbd_pkg::REG_SLICE_CODES, 32'h02);
    add_item(8'hA5, 1'b1);
    add_item(8'hFF, 1'b0);
    // four slices: byte, empty flow, bit-plane with clamped bound, empty bad code
    add_cfg(scbd_pkg::REG_PLANE_PIXELS, 32'd0);
    add_cfg(scbd_pkg::REG_CHANNEL_TOTAL, 32'd4);
    add_cfg(scbd_pkg::REG_SLICE_COUNT, 32'd7);
    add_cfg(scbd_pkg::REG_SLICE_BOUNDS, 32'h7C21);
    add_cfg(scbd_pkg::REG_SLICE_CODES, 32'hE4);
    add_item(8'h81, 1'b1);
    add_item(8'h01, 1'b0);
    add_item(8'hFE, 1'b0);
    add_cfg(scbd_pkg::REG_CHANNEL_TOTAL, 32'd1);  // current channel now lies outside the layout
    add_item(8'h40, 1'b0);
    add_item(8'hC3, 1'b1);
    add_cfg(scbd_pkg::REG_CHANNEL_TOTAL, 32'd20);
    add_cfg(scbd_pkg::REG_UNUSED_PAD, 32'd1);
    add_item(8'h7E, 1'b0);
    add_item(8'h55, 1'b0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 21;
    rx_idle_pct = 49;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 49 : 0;
      rx_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 21 : 0;
      for (int sg = 0; sg < 2; sg++) begin
        quiesce();
        if (ph == 0 && sg == 1) begin
          load_layout(32'h1FFFFF, 32'd31, 32'd7, 32'hFFFF, 32'hFF, 32'd1);
        end else if (ph == 1 && sg == 1) begin
          load_layout(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        end else begin
          load_layout(
            ($urandom_range(0, 9) == 0) ? 32'h1FFFFF :
              ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 6),
            ($urandom_range(0, 5) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 6),
            $urandom_range(0, 7),
            {16'd0, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 7)),
             5'($urandom_range(0, 7)), 5'($urandom_range(0, 7))},
            $urandom_range(0, 255),
            $urandom_range(0, 1));
        end
        if (ph == 2 && sg == 0) hold_req = 1'b1;
        for (int j = 0; j < SEG_ITEMS; j++) begin
          st = (j == 0) || ($urandom_range(0, 19) == 0);
          case ($urandom_range(0, 15))
            0, 1:    d = 8'hFF;
            2, 3:    d = 8'h7F;
            4:       d = 8'h00;
            5:       d = 8'h80;
            default: d = 8'($urandom_range(0, 255));
          endcase
          send_item(d, st, 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (int w = 0; w < WATCHDOG_LIMIT && pending_elems.size() != 0; w++) @(posedge clk);
    if (pending_elems.size() != 0)
      flag_error($sformatf("%0d elements never arrived", pending_elems.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d payload bytes, checked %0d elements, %0d register writes.",
             bytes_sent, elems_checked, reg_writes);
    $display("Byte, flow, bit-plane and bad-code slices, three stall mixes, %0d-cycle hold.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
